/* hdl/utf8t_pkg.sv */
`default_nettype none

package utf8t_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned CP_W   = 21;

    localparam logic [UNIT_W-1:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [CP_W-1:0]   REPLACEMENT_CP   = 21'h00FFFD;
    localparam logic [CP_W-1:0]   SUPPLEMENTARY_BASE = 21'h010000;
    localparam logic [UNIT_W-1:0] HIGH_SURROGATE   = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_SURROGATE    = 16'hDC00;

    // One decoded byte's worth of work for the back end. A replacement
    // unit may come first (broken sequence), then an optional code point.
    typedef struct packed {
        logic            lead_fffd;
        logic            cp_valid;
        logic [CP_W-1:0] cp;
    } job_t;

endpackage

`default_nettype wire

/* hdl/utf8t_front.sv */
`default_nettype none

module utf8t_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire logic [7:0]                  data_byte,
    output logic                             job_valid,
    output utf8t_pkg::job_t                  job
);
    import utf8t_pkg::*;

    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] partial_next;
    logic [1:0]      remaining_reg;
    logic [1:0]      remaining_next;

    logic            lead_emit;
    logic [CP_W-1:0] lead_cp;
    logic [CP_W-1:0] lead_partial;
    logic [1:0]      lead_remaining;
    logic [CP_W-1:0] shifted;

    // Lead byte classification, used both for a fresh byte and for a byte
    // that broke a pending sequence.
    always_comb
    begin
        lead_emit      = 1'b0;
        lead_cp        = REPLACEMENT_CP;
        lead_partial   = '0;
        lead_remaining = 2'd0;
        if (data_byte[7] == 1'b0)
        begin
            lead_emit = 1'b1;
            lead_cp   = {{(CP_W-BYTE_W){1'b0}}, data_byte};
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            lead_partial   = {{(CP_W-5){1'b0}}, data_byte[4:0]};
            lead_remaining = 2'd1;
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            lead_partial   = {{(CP_W-4){1'b0}}, data_byte[3:0]};
            lead_remaining = 2'd2;
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            lead_partial   = {{(CP_W-3){1'b0}}, data_byte[2:0]};
            lead_remaining = 2'd3;
        end
        else
        begin
            lead_emit = 1'b1;
        end
    end

    assign shifted = {partial_reg[CP_W-7:0], data_byte[5:0]};

    always_comb
    begin
        partial_next   = partial_reg;
        remaining_next = remaining_reg;
        job.lead_fffd  = 1'b0;
        job.cp_valid   = 1'b0;
        job.cp         = lead_cp;
        if (data_byte == 8'd0)
        begin
            job.cp_valid   = (remaining_reg != 2'd0);
            job.cp         = REPLACEMENT_CP;
            partial_next   = '0;
            remaining_next = 2'd0;
        end
        else if (remaining_reg != 2'd0)
        begin
            if (data_byte[7:6] == 2'b10)
            begin
                remaining_next = remaining_reg - 2'd1;
                if (remaining_reg == 2'd1)
                begin
                    job.cp_valid = 1'b1;
                    job.cp       = shifted;
                    partial_next = '0;
                end
                else
                begin
                    partial_next = shifted;
                end
            end
            else
            begin
                job.lead_fffd  = 1'b1;
                job.cp_valid   = lead_emit;
                partial_next   = lead_partial;
                remaining_next = lead_remaining;
            end
        end
        else
        begin
            job.cp_valid   = lead_emit;
            partial_next   = lead_partial;
            remaining_next = lead_remaining;
        end
    end

    assign job_valid = take && (job.lead_fffd || job.cp_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            remaining_reg <= 2'd0;
        end
        else if (take)
        begin
            partial_reg   <= partial_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/utf8t_queue.sv */
`default_nettype none

module utf8t_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire utf8t_pkg::job_t wr_job,
    input  wire logic            rd_en,
    output utf8t_pkg::job_t      rd_job,
    output logic                 full,
    output logic                 empty
);
    import utf8t_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/utf8t_back.sv */
`default_nettype none

module utf8t_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire utf8t_pkg::job_t head_job,
    input  wire logic            head_valid,
    input  wire logic            pop,
    output logic                 head_done,
    output logic [15:0]          code_unit,
    output logic                 last_of_run
);
    import utf8t_pkg::*;

    logic [1:0]      idx_reg;
    logic [1:0]      idx_next;
    logic            big;
    logic [1:0]      cp_units;
    logic [1:0]      unit_count;
    logic [1:0]      cp_pos;
    logic [CP_W-1:0] offset;

    assign big        = (head_job.cp[CP_W-1:16] != '0);
    assign cp_units   = head_job.cp_valid ? (big ? 2'd2 : 2'd1) : 2'd0;
    assign unit_count = {1'b0, head_job.lead_fffd} + cp_units;
    assign cp_pos     = idx_reg - {1'b0, head_job.lead_fffd};
    assign offset     = head_job.cp - SUPPLEMENTARY_BASE;

    always_comb
    begin
        if (head_job.lead_fffd && (idx_reg == 2'd0))
        begin
            code_unit = REPLACEMENT_UNIT;
        end
        else if (big)
        begin
            code_unit = (cp_pos == 2'd0)
                      ? (HIGH_SURROGATE | {5'd0, offset[20:10]})
                      : (LOW_SURROGATE  | {6'd0, offset[9:0]});
        end
        else
        begin
            code_unit = head_job.cp[15:0];
        end
    end

    assign last_of_run = (idx_reg == unit_count - 2'd1);
    assign head_done   = head_valid && pop && last_of_run;

    always_comb
    begin
        idx_next = idx_reg;
        if (head_valid && pop)
        begin
            idx_next = last_of_run ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/utf8_to_utf16_transcoder.sv */
`default_nettype none

// Channel   Ports                             Request taken when
// input     push, full, data_byte[7:0]        push && !full
// result    pop, empty, code_unit[15:0],      pop && !empty
//           last_of_run
//
// One UTF-8 byte is taken per cycle while the job queue has room; the front
// decoder settles each byte in the cycle it is accepted. Each byte yields
// zero, one or two UTF-16 units, which leave one per cycle, so the output
// side sets the sustained rate when bytes produce surrogate pairs or broken
// sequences. Reset clears the decoder state, the queue and the unit index.
// A stalled result holds; the input stalls only when QUEUE_DEPTH jobs wait.
module utf8_to_utf16_transcoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      code_unit,
    output logic             last_of_run
);
    import utf8t_pkg::*;

    // The front end owns the decoder state, so it advances on every
    // accepted request, whether or not the byte produces any output.
    logic take;
    logic job_valid;
    job_t new_job;
    job_t head_job;
    logic queue_empty;
    logic head_done;

    assign take  = push && !full;
    assign empty = queue_empty;

    utf8t_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .job_valid (job_valid),
        .job       (new_job)
    );

    // The queue decouples decoding from unit emission; a job stays at its
    // head until its last unit has been popped.
    utf8t_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_valid),
        .wr_job (new_job),
        .rd_en  (head_done),
        .rd_job (head_job),
        .full   (full),
        .empty  (queue_empty)
    );

    // The back end turns a job into its replacement unit, plain unit or
    // surrogate pair, one unit per pop.
    utf8t_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .head_valid  (!queue_empty),
        .pop         (pop),
        .head_done   (head_done),
        .code_unit   (code_unit),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
